// File: src/brf_pkg.sv
// Shared types and codes for the byte ring FIFO.
package brf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [COUNT_W-1:0] QSIZE_RST = 9'd256;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BYTE_W-1:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic [BYTE_W-1:0]  data_out;
        logic [COUNT_W-1:0] occupancy;
        logic [COUNT_W-1:0] free_space;
    } t_out_item;

    // Outcome of one step, handed from the index logic to the output stage
    typedef struct packed {
        logic               accepted;
        logic               pop_ok;
        logic [COUNT_W-1:0] occupancy;
        logic [COUNT_W-1:0] free_space;
    } t_step_status;

endpackage

// File: src/brf_mem.sv
// Byte store: one write port, one read port with registered read data.
module brf_mem #(
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [brf_pkg::BYTE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [brf_pkg::BYTE_W-1:0] o_rdata
);
    import brf_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/brf_ctrl.sv
// Index, full flag, fill count and size logic of the ring.
module brf_ctrl #(
    parameter int DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [brf_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                        i_step,
    input  logic [1:0]                  i_op,
    output logic                        o_mem_we,
    output logic [$clog2(DEPTH)-1:0]    o_mem_waddr,
    output logic                        o_mem_re,
    output logic [$clog2(DEPTH)-1:0]    o_mem_raddr,
    output brf_pkg::t_step_status       o_status
);
    import brf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam logic [SW-1:0] SIZE_RST =
        SW'((DEPTH < int'(QSIZE_RST)) ? DEPTH : int'(QSIZE_RST));

    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic          r_full,   n_full;
    logic [SW-1:0] r_count,  n_count;
    logic [SW-1:0] r_size;
    logic [SW-1:0] w_cfg_size;
    logic [AW-1:0] w_wr_inc, w_rd_inc;
    logic          w_accepted, w_pop_ok, w_mem_we, w_mem_re;

    // Clamp the written size to 1..DEPTH
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_size = SW'(1);
        end else if (int'(i_cfg_wdata) > DEPTH) begin
            w_cfg_size = SW'(DEPTH);
        end else begin
            w_cfg_size = SW'(i_cfg_wdata);
        end
    end

    assign w_wr_inc = ((SW'(r_wr_idx) + SW'(1)) == r_size) ? '0 : r_wr_idx + AW'(1);
    assign w_rd_inc = ((SW'(r_rd_idx) + SW'(1)) == r_size) ? '0 : r_rd_idx + AW'(1);

    always_comb begin
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_full     = r_full;
        n_count    = r_count;
        w_accepted = 1'b0;
        w_pop_ok   = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        if (i_step) begin
            case (i_op)
                OP_PUSH: begin
                    if (!r_full) begin
                        w_mem_we   = 1'b1;
                        n_wr_idx   = w_wr_inc;
                        n_full     = (w_wr_inc == r_rd_idx);
                        n_count    = r_count + SW'(1);
                        w_accepted = 1'b1;
                    end
                end
                OP_POP: begin
                    if (r_count != '0) begin
                        w_mem_re   = 1'b1;
                        n_rd_idx   = w_rd_inc;
                        n_full     = 1'b0;
                        n_count    = r_count - SW'(1);
                        w_accepted = 1'b1;
                        w_pop_ok   = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_wr_idx   = '0;
                    n_rd_idx   = '0;
                    n_full     = 1'b0;
                    n_count    = '0;
                    w_accepted = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_full   <= 1'b0;
            r_count  <= '0;
            r_size   <= SIZE_RST;
        end else if (i_cfg_we) begin
            // A new size empties the queue
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_full   <= 1'b0;
            r_count  <= '0;
            r_size   <= w_cfg_size;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_full   <= n_full;
            r_count  <= n_count;
        end
    end

    assign o_mem_we    = w_mem_we;
    assign o_mem_waddr = r_wr_idx;
    assign o_mem_re    = w_mem_re;
    assign o_mem_raddr = r_rd_idx;

    assign o_status.accepted   = w_accepted;
    assign o_status.pop_ok     = w_pop_ok;
    assign o_status.occupancy  = COUNT_W'(n_count);
    assign o_status.free_space = COUNT_W'(r_size - n_count);

`ifndef ASSERT_OFF
    a_count_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_size)
        else $error("fill count exceeds queue size");

    a_full_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full == (r_count == r_size))
        else $error("full flag disagrees with fill count");

    a_indices_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_wr_idx) < r_size) && (SW'(r_rd_idx) < r_size))
        else $error("ring index outside queue size");
`endif

endmodule

// File: src/byte_ring_fifo_top.sv
// Top level of the byte ring FIFO: handshakes, result pipeline, store and index logic.
//
// Usage
//   Input channel i_in_valid / o_in_ready carries one item: a push, a pop or
//   a clear. Each transfer yields exactly one result on o_out_valid /
//   i_out_ready, reporting acceptance, the popped byte (zero otherwise), the
//   fill level and the free space after the step.
//   i_cfg_we writes the queue size (clamped to 1..DEPTH) and empties the
//   queue; write it only while no result is outstanding.
// Pipeline and throughput
//   A result passes the store read and the pending register, both loaded at the
//   transfer edge, and then the output register.
//   One item per cycle is sustained while the receiver takes results; the
//   store does at most one access per item and indices update in the same cycle.
// Reset
//   Synchronous active-low reset empties the queue and sets the size to
//   the smaller of 256 and DEPTH. Store contents are not cleared.
// Stall
//   When the receiver holds i_out_ready low, the output register and one
//   pending stage fill, then o_in_ready drops until a result is taken.
module byte_ring_fifo_top #(
    parameter int DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [brf_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  brf_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output brf_pkg::t_out_item          o_out_data
);
    import brf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              w_in_xfer;
    logic              w_move;
    logic              w_mem_we, w_mem_re;
    logic [AW-1:0]     w_mem_waddr, w_mem_raddr;
    logic [BYTE_W-1:0] w_mem_rdata;
    t_step_status      w_status;

    logic              r_pend_valid;
    t_step_status      r_pend_status;
    logic              r_out_valid;
    t_out_item         r_out_data;

    // Advance the pending step once the output register is free
    assign w_move     = r_pend_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_pend_valid || w_move;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    brf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_in_xfer),
        .i_op        (i_in_data.operation),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .o_status    (w_status)
    );

    brf_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (i_in_data.data_in),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_pend_valid <= 1'b1;
        end else if (w_move) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_pend_status <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_data.accepted   <= r_pend_status.accepted;
            r_out_data.data_out   <= r_pend_status.pop_ok ? w_mem_rdata : '0;
            r_out_data.occupancy  <= r_pend_status.occupancy;
            r_out_data.free_space <= r_pend_status.free_space;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    a_refused_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data.accepted |-> r_out_data.data_out == '0)
        else $error("refused step carries a data byte");

    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid && !w_move |=> r_pend_valid && $stable(r_pend_status))
        else $error("pending step lost while output stalled");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_pend_valid && r_out_valid && !i_out_ready)
        else $error("input stalled while the pipeline has room");
`endif

endmodule
